FILE: sv/gcp_pkg.sv
package gcp_pkg;

	localparam int PIX_W  = 8;
	localparam int GAIN_W = 16;
	localparam int ACT_W  = 2;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 16;
	localparam int PROD_W = PIX_W + GAIN_W;

	localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RESOLVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_APPLY   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WHITE = 2'd2;

	localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
	localparam logic [GAIN_W-1:0] GAIN_NEAR_LO = 16'd4092;
	localparam logic [GAIN_W-1:0] GAIN_NEAR_HI = 16'd4100;
	localparam logic [PROD_W-1:0] CLIP_LIMIT = 24'd1044480;
	localparam logic [PIX_W-1:0]  PIX_FULL   = 8'd255;

	localparam int MAX_PIXELS_DEF = 4096;
	localparam int LOCK_LINES_DEF = 96;

	// Quotients of both divisions never exceed 255.
	localparam int QUO_W = 8;

	typedef struct packed {
		logic load;
		logic white;
		logic start;
	} lane_ctl_t;

endpackage

FILE: sv/gcp_if.sv
interface gcp_in_if import gcp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [PIX_W-1:0]   red_in;
	logic [PIX_W-1:0]   green_in;
	logic [PIX_W-1:0]   blue_in;

	modport source (output valid, action, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface gcp_out_if import gcp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   red_out;
	logic [PIX_W-1:0]   green_out;
	logic [PIX_W-1:0]   blue_out;
	logic               white_background;
	logic               pixel_changed;

	modport source (output valid, red_out, green_out, blue_out, white_background,
		pixel_changed, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, white_background,
		pixel_changed, output ready);
endinterface

FILE: sv/joint_clip_rgb_gain_auto_polarity_core.sv
// RGB line gain with joint clipping and automatic background polarity. Words
// are taken one at a time: a measure word, a resolve word on a line with no
// samples or with gain disabled, and an apply word that needs no joint
// clipping finish in ST_EXEC. An apply word that clips, and a resolve word
// that forms a line mean from samples, go on to ST_DIV or ST_MEAN to wait
// for the 8-step shared-nothing restoring dividers (one per color lane for
// the joint scale, one for the line mean). A finished word sits in the output
// register, and the next word is taken as soon as that register is free or
// being emptied. Configuration is written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; the user must ensure this, as the block does not check it.
module joint_clip_rgb_gain_auto_polarity_core import gcp_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int LOCK_LINES = LOCK_LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	gcp_in_if.sink            din,
	gcp_out_if.source         dout
);

	localparam int POS_W   = $clog2(MAX_PIXELS + 1);
	localparam int CNT_MAX = (MAX_PIXELS + 7) / 8;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int SUM_W   = $clog2(CNT_MAX * 765 + 1);
	localparam int MDEN_W  = $clog2(3 * CNT_MAX + 1);
	localparam int LCK_W   = $clog2(LOCK_LINES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_MEAN = 2'd3;

	logic [1:0]        state_q;

	logic              enable_q;
	logic [GAIN_W-1:0] gain_q;
	logic [MODE_W-1:0] mode_q;

	logic [SUM_W-1:0]  sample_sum_q;
	logic [CNT_W-1:0]  sample_count_q;
	logic [POS_W-1:0]  pixel_pos_q;
	logic              polarity_q;
	logic              locked_q;
	logic [LCK_W-1:0]  countdown_q;
	logic [PIX_W-1:0]  max_mean_q;
	logic [PIX_W-1:0]  min_mean_q;
	logic              gain_was_active_q;

	logic [ACT_W-1:0]  act_q;
	logic [PIX_W-1:0]  px_q [3];

	logic              out_valid_q;
	logic [PIX_W-1:0]  out_px_q [3];
	logic              out_white_q;
	logic              out_changed_q;

	logic              accept;
	logic              auto_mode;
	logic              pole_now;
	logic              gain_on;
	logic              near_unity;

	lane_ctl_t         lane_ctl;
	logic [PIX_W-1:0]  lane_pix [3];
	logic [PIX_W-1:0]  lane_e   [3];
	logic              lane_clip[3];
	logic [PIX_W-1:0]  lane_qlin[3];
	logic [PIX_W-1:0]  lane_qdiv[3];
	logic              lane_done[3];

	logic [PIX_W-1:0]  emax;
	logic              any_clip;
	logic              lane_start;

	logic              mean_start;
	logic              mean_done;
	logic [PIX_W-1:0]  mean_quot;
	logic [MDEN_W-1:0] mean_den;

	logic              fin;
	logic              res_fin;
	logic [PIX_W-1:0]  mean_sel;
	logic              learn;
	logic [PIX_W-1:0]  new_max;
	logic [PIX_W-1:0]  new_min;
	logic              pol_learn;
	logic              pol_next;
	logic              white_next;
	logic [PIX_W-1:0]  q_sel   [3];
	logic [PIX_W-1:0]  res_px  [3];
	logic              changed;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			gain_q   <= GAIN_UNITY;
			mode_q   <= MODE_AUTO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_GAIN:   gain_q   <= cfg_wdata[GAIN_W-1:0];
				REG_MODE:   mode_q   <= cfg_wdata[MODE_W-1:0];
				default:    ;
			endcase
		end
	end

	assign accept     = din.valid && din.ready;
	assign din.ready  = (state_q == ST_IDLE) && (!out_valid_q || dout.ready);
	assign auto_mode  = (mode_q != MODE_BLACK) && (mode_q != MODE_WHITE);
	assign pole_now   = (mode_q == MODE_BLACK) ? 1'b0 :
		(mode_q == MODE_WHITE) ? 1'b1 : polarity_q;
	assign near_unity = (gain_q >= GAIN_NEAR_LO) && (gain_q <= GAIN_NEAR_HI);
	assign gain_on    = enable_q && !near_unity;

	assign lane_pix[0] = din.red_in;
	assign lane_pix[1] = din.green_in;
	assign lane_pix[2] = din.blue_in;

	assign lane_ctl.load  = accept;
	assign lane_ctl.white = pole_now;
	assign lane_ctl.start = lane_start;

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		gcp_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.pixel   (lane_pix[ch]),
			.gain    (gain_q),
			.emax    (emax),
			.energy  (lane_e[ch]),
			.clip    (lane_clip[ch]),
			.q_lin   (lane_qlin[ch]),
			.q_div   (lane_qdiv[ch]),
			.div_done(lane_done[ch])
		);
	end

	// Merge: the peak energy and the joint clip decision across the lanes.
	always_comb begin
		emax = lane_e[0];
		if (lane_e[1] > emax) emax = lane_e[1];
		if (lane_e[2] > emax) emax = lane_e[2];
	end
	assign any_clip = lane_clip[0] || lane_clip[1] || lane_clip[2];

	assign mean_den = ({sample_count_q, 1'b0} + MDEN_W'(sample_count_q));

	gcp_div #(
		.NUM_W(SUM_W),
		.DEN_W(MDEN_W),
		.QW   (PIX_W)
	) u_mean_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mean_start),
		.num   (sample_sum_q),
		.den   (mean_den),
		.quot  (mean_quot),
		.done  (mean_done)
	);

	always_comb begin
		fin        = 1'b0;
		res_fin    = 1'b0;
		lane_start = 1'b0;
		mean_start = 1'b0;
		mean_sel   = PIX_FULL;
		case (state_q)
			ST_EXEC: begin
				case (act_q)
					ACT_RESOLVE: begin
						if ((pixel_pos_q != '0) && enable_q && (sample_count_q != '0)) begin
							mean_start = 1'b1;
						end else begin
							fin     = 1'b1;
							res_fin = 1'b1;
						end
					end
					ACT_APPLY: begin
						if (gain_on && any_clip && (emax != '0)) begin
							lane_start = 1'b1;
						end else begin
							fin = 1'b1;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_DIV:  fin = lane_done[0];
			ST_MEAN: begin
				fin      = mean_done;
				res_fin  = mean_done;
				mean_sel = mean_quot;
			end
			default: ;
		endcase
	end

	// Learning update at the end of a measure pass.
	assign learn     = res_fin && (pixel_pos_q != '0) && enable_q && auto_mode && !locked_q;
	assign new_max   = (mean_sel > max_mean_q) ? mean_sel : max_mean_q;
	assign new_min   = (mean_sel < min_mean_q) ? mean_sel : min_mean_q;
	assign pol_learn = ({1'b0, new_max} + {1'b0, new_min}) > {1'b0, PIX_FULL};
	assign pol_next  = learn ? pol_learn : polarity_q;
	assign white_next = (mode_q == MODE_BLACK) ? 1'b0 :
		(mode_q == MODE_WHITE) ? 1'b1 : pol_next;

	always_comb begin
		changed = 1'b0;
		for (int ch = 0; ch < 3; ch++) begin
			q_sel[ch] = (state_q == ST_DIV) ? lane_qdiv[ch] : lane_qlin[ch];
			if ((act_q == ACT_APPLY) && gain_on) begin
				res_px[ch] = pole_now ? (PIX_FULL - q_sel[ch]) : q_sel[ch];
			end else begin
				res_px[ch] = px_q[ch];
			end
			if (res_px[ch] != px_q[ch]) changed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (lane_start) begin
						state_q <= ST_DIV;
					end else if (mean_start) begin
						state_q <= ST_MEAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV:  if (fin) state_q <= ST_IDLE;
				ST_MEAN: if (fin) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= din.action;
			px_q[0] <= din.red_in;
			px_q[1] <= din.green_in;
			px_q[2] <= din.blue_in;
		end
	end

	// Line statistics and background learning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q      <= '0;
			sample_count_q    <= '0;
			pixel_pos_q       <= '0;
			polarity_q        <= 1'b1;
			locked_q          <= 1'b0;
			countdown_q       <= LCK_W'(LOCK_LINES);
			max_mean_q        <= '0;
			min_mean_q        <= PIX_FULL;
			gain_was_active_q <= 1'b0;
		end else begin
			if ((state_q == ST_EXEC) && (act_q == ACT_MEASURE)
				&& (pixel_pos_q < POS_W'(MAX_PIXELS))) begin
				if (pixel_pos_q[2:0] == 3'd0) begin
					sample_sum_q   <= sample_sum_q + SUM_W'(px_q[0]) + SUM_W'(px_q[1])
						+ SUM_W'(px_q[2]);
					sample_count_q <= sample_count_q + 1'b1;
				end
				pixel_pos_q <= pixel_pos_q + 1'b1;
			end
			if (res_fin) begin
				sample_sum_q   <= '0;
				sample_count_q <= '0;
				pixel_pos_q    <= '0;
				if (pixel_pos_q != '0) begin
					if (!enable_q) begin
						if (gain_was_active_q) begin
							gain_was_active_q <= 1'b0;
							locked_q          <= 1'b0;
							countdown_q       <= LCK_W'(LOCK_LINES);
							max_mean_q        <= '0;
							min_mean_q        <= PIX_FULL;
						end
					end else begin
						gain_was_active_q <= 1'b1;
						if (learn) begin
							max_mean_q <= new_max;
							min_mean_q <= new_min;
							polarity_q <= pol_learn;
							if (countdown_q <= LCK_W'(1)) begin
								countdown_q <= '0;
								locked_q    <= 1'b1;
							end else begin
								countdown_q <= countdown_q - 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_px_q[0]   <= res_px[0];
			out_px_q[1]   <= res_px[1];
			out_px_q[2]   <= res_px[2];
			out_white_q   <= white_next;
			out_changed_q <= changed;
		end
	end

	assign dout.valid            = out_valid_q;
	assign dout.red_out          = out_px_q[0];
	assign dout.green_out        = out_px_q[1];
	assign dout.blue_out         = out_px_q[2];
	assign dout.white_background = out_white_q;
	assign dout.pixel_changed    = out_changed_q;

endmodule

FILE: sv/gcp_div.sv
module gcp_div import gcp_pkg::*; #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 9,
	parameter int QW    = QUO_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QW-1:0]    quot,
	output logic             done
);

	// Restoring division, one quotient bit per cycle, MSB first. The caller
	// guarantees num < den << QW, so QW steps give the full quotient.
	localparam int SH_W  = DEN_W + QW - 1;
	localparam int W     = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

	logic [W-1:0]     rem_q;
	logic [W-1:0]     dsh_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(num);
			dsh_q <= W'({den, {(QW-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

FILE: sv/gcp_lane.sv
module gcp_lane import gcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_ctl_t        ctl,
	input  logic [PIX_W-1:0] pixel,
	input  logic [GAIN_W-1:0] gain,
	input  logic [PIX_W-1:0] emax,
	output logic [PIX_W-1:0] energy,
	output logic             clip,
	output logic [PIX_W-1:0] q_lin,
	output logic [PIX_W-1:0] q_div,
	output logic             div_done
);

	localparam int NUM_W = 17;
	localparam int DEN_W = PIX_W + 1;

	logic [PIX_W-1:0]  e_d;
	logic [PIX_W-1:0]  e_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W:0]   rounded;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;

	assign e_d = ctl.white ? (PIX_FULL - pixel) : pixel;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			e_s1    <= e_d;
			prod_s1 <= PROD_W'(e_d) * PROD_W'(gain);
		end
	end

	assign energy  = e_s1;
	assign clip    = (prod_s1 > CLIP_LIMIT);
	assign rounded = {1'b0, prod_s1} + (PROD_W+1)'(2048);
	// Without clipping the product is at most 255*4096, so this stays in range.
	assign q_lin   = rounded[19:12];

	// 255*e/emax rounded half up, as (510*e + emax) / (2*emax).
	assign div_num = NUM_W'(e_s1) * NUM_W'(510) + NUM_W'(emax);
	assign div_den = {emax, 1'b0};

	gcp_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QW   (PIX_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.start),
		.num   (div_num),
		.den   (div_den),
		.quot  (q_div),
		.done  (div_done)
	);

endmodule

FILE: tb/sv/tb_joint_clip_rgb_gain_auto_polarity_core.sv
module tb_joint_clip_rgb_gain_auto_polarity_core import gcp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] MODE_AUTO_ALT = 2'd3;
	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam int DRAIN_PAD = 12;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_word_t;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic white;
		logic changed;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	gcp_in_if din_bus ();
	gcp_out_if dout_bus ();

	joint_clip_rgb_gain_auto_polarity_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.din(din_bus),
		.dout(dout_bus)
	);

	always #5 clk = ~clk;

	// Mirror of the registers and of the line/learning state.
	logic en_reg = 1'b0;
	logic [GAIN_W-1:0] gain_reg = GAIN_UNITY;
	logic [MODE_W-1:0] mode_reg = MODE_AUTO;
	logic [18:0] line_sum = '0;
	logic [9:0] line_samples = '0;
	logic [12:0] line_pos = '0;
	logic pole_white = 1'b1;
	logic learn_locked = 1'b0;
	logic [6:0] lock_left = 7'(LOCK_LINES_DEF);
	logic [PIX_W-1:0] mean_max = '0;
	logic [PIX_W-1:0] mean_min = PIX_FULL;
	logic gain_used = 1'b0;

	pix_word_t words_to_send[$];
	pix_result_t pixel_results_due[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic logic pole_now();
		if (mode_reg == MODE_BLACK) return 1'b0;
		if (mode_reg == MODE_WHITE) return 1'b1;
		return pole_white;
	endfunction

	task automatic compute_pixel_result(input pix_word_t w);
		pix_result_t r;
		int px [3];
		int e [3];
		int res [3];
		int emax;
		int q;
		int g;
		int mean;
		logic white;
		logic clip;
		logic changed;
		px[0] = int'(w.red);
		px[1] = int'(w.green);
		px[2] = int'(w.blue);
		res = px;
		changed = 1'b0;
		case (w.action)
		ACT_MEASURE: begin
			if (int'(line_pos) < MAX_PIXELS_DEF) begin
				if (line_pos[2:0] == 3'd0) begin
					line_sum = line_sum + 19'(px[0] + px[1] + px[2]);
					line_samples = line_samples + 10'd1;
				end
				line_pos = line_pos + 13'd1;
			end
		end
		ACT_RESOLVE: begin
			if (line_pos != '0) begin
				if (!en_reg) begin
					// Turning the gain off re-arms learning for the next time it is on.
					if (gain_used) begin
						gain_used = 1'b0;
						learn_locked = 1'b0;
						lock_left = 7'(LOCK_LINES_DEF);
						mean_max = '0;
						mean_min = PIX_FULL;
					end
				end else begin
					mean = (line_samples != '0) ?
						int'(line_sum) / (3 * int'(line_samples)) : 255;
					gain_used = 1'b1;
					if (mode_reg != MODE_BLACK && mode_reg != MODE_WHITE && !learn_locked) begin
						if (mean > int'(mean_max)) mean_max = PIX_W'(mean);
						if (mean < int'(mean_min)) mean_min = PIX_W'(mean);
						pole_white = (int'(mean_max) + int'(mean_min) > 255);
						if (lock_left <= 7'd1) begin
							lock_left = '0;
							learn_locked = 1'b1;
						end else begin
							lock_left = lock_left - 7'd1;
						end
					end
				end
			end
			line_sum = '0;
			line_samples = '0;
			line_pos = '0;
		end
		ACT_APPLY: begin
			if (en_reg && (gain_reg < GAIN_NEAR_LO || gain_reg > GAIN_NEAR_HI)) begin
				white = pole_now();
				g = int'(gain_reg);
				emax = 0;
				clip = 1'b0;
				for (int c = 0; c < 3; c++) begin
					e[c] = white ? 255 - px[c] : px[c];
					if (e[c] > emax) emax = e[c];
					if (e[c] * g > int'(CLIP_LIMIT)) clip = 1'b1;
				end
				for (int c = 0; c < 3; c++) begin
					// A clipping pixel is scaled as a whole so its peak lands on full scale.
					if (clip && emax > 0)
						q = (510 * e[c] + emax) / (2 * emax);
					else
						q = (e[c] * g + 2048) / 4096;
					if (q > 255) q = 255;
					res[c] = white ? 255 - q : q;
					if (res[c] != px[c]) changed = 1'b1;
				end
			end
		end
		default: ;
		endcase
		r.red = PIX_W'(res[0]);
		r.green = PIX_W'(res[1]);
		r.blue = PIX_W'(res[2]);
		r.white = pole_now();
		r.changed = changed;
		pixel_results_due.push_back(r);
	endtask

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin : drive_words
		pix_word_t nxt;
		pix_word_t took;
		if (!arst_n) begin
			din_bus.valid <= 1'b0;
		end else begin
			if (din_bus.valid && din_bus.ready) begin
				took.action = din_bus.action;
				took.red = din_bus.red_in;
				took.green = din_bus.green_in;
				took.blue = din_bus.blue_in;
				compute_pixel_result(took);
			end
			if (!din_bus.valid || din_bus.ready) begin
				if (words_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = words_to_send.pop_front();
					din_bus.valid <= 1'b1;
					din_bus.action <= nxt.action;
					din_bus.red_in <= nxt.red;
					din_bus.green_in <= nxt.green;
					din_bus.blue_in <= nxt.blue;
				end else begin
					din_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_words
		pix_result_t want;
		if (!arst_n) begin
			dout_bus.ready <= 1'b0;
		end else begin
			if (dout_bus.valid && dout_bus.ready) begin
				if (pixel_results_due.size() == 0) begin
					flag_mismatch("output word with nothing outstanding");
				end else begin
					want = pixel_results_due.pop_front();
					if (dout_bus.red_out !== want.red)
						flag_mismatch($sformatf("red_out %0d, want %0d", dout_bus.red_out, want.red));
					if (dout_bus.green_out !== want.green)
						flag_mismatch($sformatf("green_out %0d, want %0d",
							dout_bus.green_out, want.green));
					if (dout_bus.blue_out !== want.blue)
						flag_mismatch($sformatf("blue_out %0d, want %0d",
							dout_bus.blue_out, want.blue));
					if (dout_bus.white_background !== want.white)
						flag_mismatch($sformatf("white_background %b, want %b",
							dout_bus.white_background, want.white));
					if (dout_bus.pixel_changed !== want.changed)
						flag_mismatch($sformatf("pixel_changed %b, want %b",
							dout_bus.pixel_changed, want.changed));
				end
			end
			dout_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_ENABLE: en_reg = val[0];
		REG_GAIN:   gain_reg = val;
		REG_MODE:   mode_reg = val[MODE_W-1:0];
		default: ;
		endcase
	endtask

	// Sampled away from the rising edge so the driver's updates have settled.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || din_bus.valid || pixel_results_due.size() != 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic push_word(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		pix_word_t w;
		w.action = act;
		w.red = r;
		w.green = g;
		w.blue = b;
		words_to_send.push_back(w);
	endtask

	function automatic logic [PIX_W-1:0] near_level(input int level);
		int v;
		if ($urandom_range(0, 4) == 0) return PIX_W'($urandom_range(0, 255));
		v = level + int'($urandom_range(0, 48)) - 24;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return PIX_W'(v);
	endfunction

	// One line: a measure pass around a common brightness, the resolve word, then
	// an apply pass. Stray words of any action are mixed in when noisy, and the resolve word is then sometimes skipped.
	task automatic queue_line(input int measure_len, input int apply_len, input logic noisy);
		int level;
		if ($urandom_range(0, 3) == 0)
			level = $urandom_range(0, 1) ? 255 : 0;
		else
			level = $urandom_range(0, 255);
		for (int i = 0; i < measure_len + apply_len + 1; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_word(ACT_W'($urandom_range(0, 3)), PIX_W'($urandom), PIX_W'($urandom),
					PIX_W'($urandom));
			if (i < measure_len)
				push_word(ACT_MEASURE, near_level(level), near_level(level), near_level(level));
			else if (i > measure_len)
				push_word(ACT_APPLY, near_level(level), near_level(level), near_level(level));
			else if (!noisy || $urandom_range(0, 19) != 0)
				push_word(ACT_RESOLVE, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
		end
	endtask

	task automatic run_phase(input logic en, input logic [GAIN_W-1:0] g,
		input logic [MODE_W-1:0] m, input int send_pct, input int recv_pct,
		input int lines, input logic long_line);
		wait_drained();
		// Upper bits of the narrow registers carry junk that must be dropped.
		write_reg(REG_ENABLE, {15'($urandom), en});
		write_reg(REG_GAIN, g);
		write_reg(REG_MODE, {14'($urandom), m});
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (long_line) queue_line(MAX_PIXELS_DEF + 4, 6, 1'b0);
		for (int n = 0; n < lines; n++) begin
			// Let the block run dry halfway through every phase.
			if (n == lines / 2) wait_drained();
			queue_line($urandom_range(1, 8), $urandom_range(0, 6), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_wdata = '0;
		din_bus.valid = 1'b0;
		din_bus.action = ACT_MEASURE;
		din_bus.red_in = '0;
		din_bus.green_in = '0;
		din_bus.blue_in = '0;
		dout_bus.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: gain off, so everything passes through.
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		push_word(ACT_MEASURE, 8'd255, 8'd0, 8'd255);
		push_word(ACT_APPLY, 8'd0, 8'd255, 8'd0);
		push_word(ACT_RESOLVE, 8'd255, 8'd255, 8'd255);
		push_word(ACT_UNUSED, 8'd170, 8'd85, 8'd170);
		wait_drained();
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_GAIN, GAIN_NEAR_HI);
		write_reg(REG_NONE, 16'hFFFF);
		push_word(ACT_APPLY, 8'd12, 8'd34, 8'd56);
		wait_drained();
		write_reg(REG_GAIN, GAIN_NEAR_HI + 16'd1);
		push_word(ACT_APPLY, 8'd12, 8'd34, 8'd56);
		wait_drained();
		write_reg(REG_GAIN, 16'hFFFF);
		push_word(ACT_MEASURE, 8'd0, 8'd0, 8'd0);
		push_word(ACT_MEASURE, 8'd255, 8'd255, 8'd255);
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		push_word(ACT_APPLY, 8'd255, 8'd255, 8'd255);
		push_word(ACT_APPLY, 8'd0, 8'd0, 8'd0);
		push_word(ACT_APPLY, 8'd10, 8'd128, 8'd250);
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		wait_drained();
		write_reg(REG_MODE, {14'd0, MODE_BLACK});
		write_reg(REG_GAIN, 16'd0);
		push_word(ACT_APPLY, 8'd255, 8'd255, 8'd255);
		push_word(ACT_MEASURE, 8'd9, 8'd9, 8'd9);
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		wait_drained();
		write_reg(REG_MODE, {14'd0, MODE_WHITE});
		write_reg(REG_GAIN, 16'd8192);
		push_word(ACT_APPLY, 8'd1, 8'd2, 8'd3);
		push_word(ACT_APPLY, 8'd200, 8'd100, 8'd50);
		wait_drained();
		write_reg(REG_MODE, {14'd0, MODE_AUTO_ALT});
		write_reg(REG_GAIN, GAIN_NEAR_LO - 16'd1);
		push_word(ACT_MEASURE, 8'd30, 8'd60, 8'd90);
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		push_word(ACT_APPLY, 8'd30, 8'd60, 8'd90);
		wait_drained();
		write_reg(REG_ENABLE, 16'd0);
		push_word(ACT_MEASURE, 8'd1, 8'd1, 8'd1);
		push_word(ACT_RESOLVE, 8'd0, 8'd0, 8'd0);
		push_word(ACT_APPLY, 8'd1, 8'd1, 8'd1);

		// Four enabled auto phases give enough lines for the learning to lock.
		run_phase(1'b1, GAIN_W'($urandom_range(4101, 12288)), MODE_AUTO, 0, 0, 28, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom_range(4101, 65535)), MODE_AUTO, 86, 0, 28, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom_range(1024, 4091)), MODE_AUTO_ALT, 0, 86, 28, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom), MODE_AUTO, 38, 38, 28, 1'b0);
		run_phase(1'b0, GAIN_W'($urandom), MODE_AUTO, 0, 0, 10, 1'b0);
		run_phase(1'b1, 16'd0, MODE_BLACK, 86, 0, 16, 1'b0);
		run_phase(1'b1, 16'hFFFF, MODE_WHITE, 0, 86, 16, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom_range(int'(GAIN_NEAR_LO), int'(GAIN_NEAR_HI))),
			MODE_AUTO, 38, 38, 12, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom), MODE_W'($urandom_range(0, 3)), 0, 0, 24, 1'b0);
		run_phase(1'b1, GAIN_W'($urandom), MODE_AUTO, 38, 38, 14, 1'b0);
		wait_drained();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
